@@ design/tccs_pkg.sv @@
// ============================================================================
// tccs_pkg
// Shared constants and control/status types for the text console screen.
// ============================================================================
`default_nettype none

package tccs_pkg;

    // default screen geometry
    localparam int DEF_COLS = 64;
    localparam int DEF_ROWS = 32;

    // field widths of the word interfaces
    localparam int KIND_W = 3;
    localparam int CHAR_W = 8;
    localparam int TCOL_W = 6;
    localparam int TROW_W = 5;

    // command kinds
    localparam logic [KIND_W-1:0] KIND_PUT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SET   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BACK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FWD   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GOTO  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd5;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd6;

    // special character codes
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;

    // controller -> datapath commands
    typedef struct packed {
        logic latch_item;   // capture the input word
        logic step;         // apply cursor update / cell write / clear
        logic fill_start;   // reset the row blanking counter
        logic fill_en;      // write one blank into the cursor row
        logic rd_en;        // read the target cell
        logic load_out;     // load the result register
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic need_fill;    // cell write aimed at a row not yet blanked
        logic is_read;      // held word is a read cell
        logic fill_last;    // blanking counter on the last column
    } t_sts;

endpackage

`default_nettype wire

@@ design/text_console_cursor_screen_core.sv @@
// ============================================================================
// text_console_cursor_screen_core
// Character-cell text screen with cursor, wrap, scroll, clear and cell read.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command word: kind,
//   character code and target cell. Output channel (o_out_valid /
//   i_out_stall) returns one word per command: the cell read (zero for
//   other kinds) and the cursor after the command.
//   Sequencing: one command at a time. Put, set, cursor moves, goto and
//   clear apply in the execute state, which also loads the result register;
//   no new command is taken until the controller is back in idle. A read
//   cell goes through the registered store read port: the execute state
//   reads the cell, the read state loads the result register. The first
//   character written into a still blank row first has the row swept with
//   spaces in the fill state. Scroll and clear apply in the execute step:
//   scroll rotates a physical row base, clear drops all per-row blank flags.
//   Reset: cursor goes home, every row is flagged blank and reads as spaces;
//   no clearing pass, commands are taken right after reset.
//   Stall: the next command is accepted while a result waits; that command
//   then holds before its result load until the waiting word is taken.
// ============================================================================
`default_nettype none

module text_console_cursor_screen_core #(
    parameter int COLS = tccs_pkg::DEF_COLS,
    parameter int ROWS = tccs_pkg::DEF_ROWS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [tccs_pkg::KIND_W-1:0] i_kind,
    input  wire logic [tccs_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic [tccs_pkg::TCOL_W-1:0] i_target_col,
    input  wire logic [tccs_pkg::TROW_W-1:0] i_target_row,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [tccs_pkg::CHAR_W-1:0] o_cell_value,
    output logic      [tccs_pkg::TCOL_W-1:0] o_cursor_col,
    output logic      [tccs_pkg::TROW_W-1:0] o_cursor_row
);

    tccs_pkg::t_cmd cmd;
    tccs_pkg::t_sts sts;

    tccs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tccs_dp #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_target_col (i_target_col),
        .i_target_row (i_target_row),
        .o_cell_value (o_cell_value),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row)
    );

endmodule

`default_nettype wire

@@ design/tccs_ctrl.sv @@
// ============================================================================
// tccs_ctrl
// Sequencing state machine: accepts a word, runs row blanking or a cell
// read when needed, and hands the result to the output register.
// ============================================================================
`default_nettype none

module tccs_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    input  wire tccs_pkg::t_sts i_sts,
    output tccs_pkg::t_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;
    localparam logic [1:0] S_READ = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_item = 1'b1;
                    n_state          = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.need_fill) begin
                    o_cmd.fill_start = 1'b1;
                    n_state          = S_FILL;
                end else if (i_sts.is_read) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_READ;
                end else if (out_free) begin
                    o_cmd.step     = 1'b1;
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_FILL: begin
                o_cmd.fill_en = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_EXEC;
                end
            end
            S_READ: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result word valid flag
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // a result is never loaded over an unconsumed one
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded while output word still stalled");

    // an accepted word always goes to execution
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_EXEC))
        else $error("accepted word not executed");

    // after blanking a row the write no longer needs a fill
    a_fill_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && i_sts.fill_last) |=>
            (r_state == S_EXEC && !i_sts.need_fill))
        else $error("row still marked unblanked after fill");

    // output valid only rises from a load
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.load_out))
        else $error("output valid without a load");

endmodule

`default_nettype wire

@@ design/tccs_dp.sv @@
// ============================================================================
// tccs_dp
// Datapath: held input word, cursor, circular row base, per-row blank flags,
// character store and the result register.
// ============================================================================
`default_nettype none

module tccs_dp #(
    parameter int COLS = tccs_pkg::DEF_COLS,
    parameter int ROWS = tccs_pkg::DEF_ROWS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tccs_pkg::t_cmd                i_cmd,
    output tccs_pkg::t_sts                     o_sts,
    input  wire logic [tccs_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [tccs_pkg::CHAR_W-1:0]   i_char_code,
    input  wire logic [tccs_pkg::TCOL_W-1:0]   i_target_col,
    input  wire logic [tccs_pkg::TROW_W-1:0]   i_target_row,
    output logic      [tccs_pkg::CHAR_W-1:0]   o_cell_value,
    output logic      [tccs_pkg::TCOL_W-1:0]   o_cursor_col,
    output logic      [tccs_pkg::TROW_W-1:0]   o_cursor_row
);

    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS << CW;
    localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

    // held input word
    logic [tccs_pkg::KIND_W-1:0] r_kind;
    logic [tccs_pkg::CHAR_W-1:0] r_code;
    logic [tccs_pkg::TCOL_W-1:0] r_tcol;
    logic [tccs_pkg::TROW_W-1:0] r_trow;

    // cursor, physical row of logical row 0, row blank flags
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [RW-1:0]   r_base;
    logic [ROWS-1:0] r_rv;
    logic [CW-1:0]   r_fcnt;

    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [RW-1:0] n_base;
    logic          scroll;
    logic          do_adv;
    logic          do_nrow;

    logic                        is_special;
    logic                        write_char;
    logic [RW-1:0]               cur_phys;
    logic [RW-1:0]               rd_phys;
    logic                        t_in_range;
    logic [CW-1:0]               t_col_l;
    logic [RW-1:0]               t_row_l;

    logic [tccs_pkg::CHAR_W-1:0] mem [DEPTH];
    logic [tccs_pkg::CHAR_W-1:0] r_rdata;
    logic                        mem_we;
    logic [AW-1:0]               mem_wa;
    logic [tccs_pkg::CHAR_W-1:0] mem_wd;
    logic [AW-1:0]               mem_ra;

    logic [tccs_pkg::CHAR_W-1:0] cell_sel;
    logic [tccs_pkg::CHAR_W-1:0] r_out_cell;
    logic [tccs_pkg::TCOL_W-1:0] r_out_col;
    logic [tccs_pkg::TROW_W-1:0] r_out_row;

    // logical row to physical row, modulo ROWS
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
                                               input logic [RW-1:0] base);
        logic [RW:0] sum;
        sum = {1'b0, lrow} + {1'b0, base};
        if (sum >= (RW+1)'(ROWS)) begin
            sum = sum - (RW+1)'(ROWS);
        end
        return sum[RW-1:0];
    endfunction

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_item) begin
            r_kind <= i_kind;
            r_code <= i_char_code;
            r_tcol <= i_target_col;
            r_trow <= i_target_row;
        end
    end

    // decode
    assign is_special = (r_code == tccs_pkg::CHAR_LF) || (r_code == tccs_pkg::CHAR_CR);
    assign write_char = ((r_kind == tccs_pkg::KIND_PUT) || (r_kind == tccs_pkg::KIND_SET))
                        && !is_special;
    assign cur_phys   = phys_row(r_row, r_base);
    assign t_in_range = (int'(r_tcol) < COLS) && (int'(r_trow) < ROWS);
    assign t_col_l    = CW'(r_tcol);
    assign t_row_l    = RW'(r_trow);
    assign rd_phys    = phys_row(t_row_l, r_base);

    assign o_sts.need_fill = write_char && !r_rv[cur_phys];
    assign o_sts.is_read   = (r_kind == tccs_pkg::KIND_READ);
    assign o_sts.fill_last = (r_fcnt == COL_LAST);

    // next cursor position
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        scroll  = 1'b0;
        do_adv  = 1'b0;
        do_nrow = 1'b0;
        case (r_kind)
            tccs_pkg::KIND_PUT: begin
                if (r_code == tccs_pkg::CHAR_CR) begin
                    n_col = '0;
                end else if (r_code == tccs_pkg::CHAR_LF) begin
                    do_nrow = 1'b1;
                end else begin
                    do_adv = 1'b1;
                end
            end
            tccs_pkg::KIND_BACK: begin
                if (r_col != '0) begin
                    n_col = r_col - 1'b1;
                end else if (r_row != '0) begin
                    n_col = COL_LAST;
                    n_row = r_row - 1'b1;
                end
            end
            tccs_pkg::KIND_FWD: begin
                do_adv = 1'b1;
            end
            tccs_pkg::KIND_GOTO: begin
                n_col = (int'(r_tcol) >= COLS) ? COL_LAST : t_col_l;
                n_row = (int'(r_trow) >= ROWS) ? ROW_LAST : t_row_l;
            end
            default: begin
            end
        endcase
        // advance with wrap, new line with scroll at the bottom
        if (do_adv && (r_col != COL_LAST)) begin
            n_col = r_col + 1'b1;
        end else if (do_adv || do_nrow) begin
            n_col = '0;
            if (r_row == ROW_LAST) begin
                scroll = 1'b1;
            end else begin
                n_row = r_row + 1'b1;
            end
        end
    end

    assign n_base = !scroll ? r_base : ((r_base == ROW_LAST) ? '0 : r_base + 1'b1);

    // cursor, row base, fill counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_base <= '0;
            r_fcnt <= '0;
        end else begin
            if (i_cmd.step) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_base <= n_base;
            end
            if (i_cmd.fill_start) begin
                r_fcnt <= '0;
            end else if (i_cmd.fill_en) begin
                r_fcnt <= r_fcnt + 1'b1;
            end
        end
    end

    // row blank flags: a cleared flag means the row reads as spaces;
    // scrolling recycles the top physical row as the new bottom row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= '0;
        end else if (i_cmd.step && (r_kind == tccs_pkg::KIND_CLEAR)) begin
            r_rv <= '0;
        end else begin
            if (i_cmd.step && scroll) begin
                r_rv[r_base] <= 1'b0;
            end
            if (i_cmd.fill_en && o_sts.fill_last) begin
                r_rv[cur_phys] <= 1'b1;
            end
        end
    end

    // character store, one write and one registered read port
    assign mem_we = (i_cmd.step && write_char) || i_cmd.fill_en;
    assign mem_wa = i_cmd.fill_en ? {cur_phys, r_fcnt} : {cur_phys, r_col};
    assign mem_wd = i_cmd.fill_en ? tccs_pkg::CHAR_BLANK : r_code;
    assign mem_ra = {rd_phys, t_col_l};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[mem_ra];
        end
    end

    // result word
    always_comb begin
        if (o_sts.is_read && t_in_range) begin
            cell_sel = r_rv[rd_phys] ? r_rdata : tccs_pkg::CHAR_BLANK;
        end else begin
            cell_sel = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_cell <= cell_sel;
            r_out_col  <= tccs_pkg::TCOL_W'(n_col);
            r_out_row  <= tccs_pkg::TROW_W'(n_row);
        end
    end

    assign o_cell_value = r_out_cell;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ============================================================================
// testbench
// Self-checking bench for text_console_cursor_screen_core. A short table of
// directed commands covers the corners (reset contents, byte extremes, CR and
// LF, wrap, scroll at the bottom row, back at top-left, clear, unused kind),
// then weighted random command streams. Results are checked against a screen
// predictor (hand-written where chk is set). Both channels idle and stall at
// random; the result side holds off once for a long stretch to back up input.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    localparam int COLS        = tccs_pkg::DEF_COLS;
    localparam int ROWS        = tccs_pkg::DEF_ROWS;
    localparam int N_RANDOM    = 1450;
    localparam int N_DIRECTED  = 25;
    localparam int HOLD_AT     = 500;    // result count at which the long hold starts
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 3000;   // cycles without any handshake
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    // kind 7 has no function in the block
    localparam logic [tccs_pkg::KIND_W-1:0] KIND_NONE = 3'd7;

    typedef struct packed {
        logic [tccs_pkg::KIND_W-1:0] kind;
        logic [tccs_pkg::CHAR_W-1:0] code;
        logic [tccs_pkg::TCOL_W-1:0] tcol;
        logic [tccs_pkg::TROW_W-1:0] trow;
    } t_cmd_word;

    typedef struct packed {
        logic [tccs_pkg::CHAR_W-1:0] chr;
        logic [tccs_pkg::TCOL_W-1:0] col;
        logic [tccs_pkg::TROW_W-1:0] row;
    } t_scr_word;

    // directed row: command, plus a hand-written result where chk is set
    typedef struct packed {
        t_cmd_word cmd;
        logic      chk;
        t_scr_word res;
    } t_dir_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [tccs_pkg::KIND_W-1:0]   i_kind;
    logic [tccs_pkg::CHAR_W-1:0]   i_char_code;
    logic [tccs_pkg::TCOL_W-1:0]   i_target_col;
    logic [tccs_pkg::TROW_W-1:0]   i_target_row;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [tccs_pkg::CHAR_W-1:0]   o_cell_value;
    logic [tccs_pkg::TCOL_W-1:0]   o_cursor_col;
    logic [tccs_pkg::TROW_W-1:0]   o_cursor_row;

    text_console_cursor_screen_core #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_target_col (i_target_col),
        .i_target_row (i_target_row),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_value (o_cell_value),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Screen predictor
    // ------------------------------------------------------------------------
    logic [tccs_pkg::CHAR_W-1:0] scr_mem [ROWS][COLS];
    int                cur_c;
    int                cur_r;
    int                scroll_cnt;

    t_scr_word         pending_words [$];
    int                tx_count;
    int                rx_count;
    int                err_count;
    int                kind_seen [8];

    function automatic void blank_screen();
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                scr_mem[r][c] = tccs_pkg::CHAR_BLANK;
            end
        end
    endfunction

    function automatic void scroll_screen();
        for (int r = 0; r < ROWS - 1; r++) begin
            for (int c = 0; c < COLS; c++) begin
                scr_mem[r][c] = scr_mem[r+1][c];
            end
        end
        for (int c = 0; c < COLS; c++) begin
            scr_mem[ROWS-1][c] = tccs_pkg::CHAR_BLANK;
        end
        cur_r = ROWS - 1;
        scroll_cnt++;
    endfunction

    function automatic void line_down();
        cur_c = 0;
        cur_r++;
        if (cur_r >= ROWS) begin
            scroll_screen();
        end
    endfunction

    function automatic void step_right();
        cur_c++;
        if (cur_c >= COLS) begin
            line_down();
        end
    endfunction

    // back one position; wraps to the end of the row above, sticks at top-left
    function automatic void step_left();
        if (cur_c > 0) begin
            cur_c--;
        end else if (cur_r > 0) begin
            cur_c = COLS - 1;
            cur_r--;
        end
    endfunction

    function automatic t_scr_word console_apply(t_cmd_word c);
        t_scr_word r;
        r.chr = '0;
        case (c.kind)
            tccs_pkg::KIND_PUT: begin
                if (c.code == tccs_pkg::CHAR_CR) begin
                    cur_c = 0;
                end else if (c.code == tccs_pkg::CHAR_LF) begin
                    line_down();
                end else begin
                    scr_mem[cur_r][cur_c] = c.code;
                    step_right();
                end
            end
            tccs_pkg::KIND_SET: begin
                if (c.code != tccs_pkg::CHAR_CR && c.code != tccs_pkg::CHAR_LF) begin
                    scr_mem[cur_r][cur_c] = c.code;
                end
            end
            tccs_pkg::KIND_BACK: begin
                step_left();
            end
            tccs_pkg::KIND_FWD: begin
                step_right();
            end
            tccs_pkg::KIND_GOTO: begin
                cur_c = (int'(c.tcol) >= COLS) ? COLS - 1 : int'(c.tcol);
                cur_r = (int'(c.trow) >= ROWS) ? ROWS - 1 : int'(c.trow);
            end
            tccs_pkg::KIND_CLEAR: begin
                blank_screen();
            end
            tccs_pkg::KIND_READ: begin
                if (int'(c.tcol) < COLS && int'(c.trow) < ROWS) begin
                    r.chr = scr_mem[c.trow][c.tcol];
                end
            end
            default: begin
            end
        endcase
        r.col = tccs_pkg::TCOL_W'(cur_c);
        r.row = tccs_pkg::TROW_W'(cur_r);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Directed commands
    // ------------------------------------------------------------------------
    t_dir_row dir_rows [N_DIRECTED] = '{
        // reset contents read as spaces
        '{'{tccs_pkg::KIND_READ,  8'h00,   6'd0,  5'd0},  1'b1,
          '{tccs_pkg::CHAR_BLANK, 6'd0,  5'd0}},
        // byte extremes
        '{'{tccs_pkg::KIND_PUT,   8'hFF,   6'd63, 5'd31}, 1'b1, '{8'h00, 6'd1,  5'd0}},
        '{'{tccs_pkg::KIND_PUT,   8'h00,   6'd0,  5'd0},  1'b1, '{8'h00, 6'd2,  5'd0}},
        '{'{tccs_pkg::KIND_READ,  8'h00,   6'd0,  5'd0},  1'b1, '{8'hFF, 6'd2,  5'd0}},
        '{'{tccs_pkg::KIND_BACK,  8'h00,   6'd0,  5'd0},  1'b1, '{8'h00, 6'd1,  5'd0}},
        // set overwrites in place; CR and LF store nothing
        '{'{tccs_pkg::KIND_SET,   8'h41,   6'd0,  5'd0},  1'b0, '{8'h00, 6'd0,  5'd0}},
        '{'{tccs_pkg::KIND_SET,   tccs_pkg::CHAR_LF, 6'd0, 5'd0}, 1'b0,
          '{8'h00, 6'd0,  5'd0}},
        '{'{tccs_pkg::KIND_SET,   tccs_pkg::CHAR_CR, 6'd0, 5'd0}, 1'b0,
          '{8'h00, 6'd0,  5'd0}},
        '{'{tccs_pkg::KIND_READ,  8'h00,   6'd1,  5'd0},  1'b0, '{8'h00, 6'd0,  5'd0}},
        // carriage return, back at top-left, line feed
        '{'{tccs_pkg::KIND_PUT,   tccs_pkg::CHAR_CR, 6'd0, 5'd0}, 1'b1,
          '{8'h00, 6'd0,  5'd0}},
        '{'{tccs_pkg::KIND_BACK,  8'h00,   6'd0,  5'd0},  1'b1, '{8'h00, 6'd0,  5'd0}},
        '{'{tccs_pkg::KIND_PUT,   tccs_pkg::CHAR_LF, 6'd0, 5'd0}, 1'b1,
          '{8'h00, 6'd0,  5'd1}},
        // back from column 0 wraps up, forward wraps down
        '{'{tccs_pkg::KIND_BACK,  8'h00,   6'd0,  5'd0},  1'b1, '{8'h00, 6'd63, 5'd0}},
        '{'{tccs_pkg::KIND_FWD,   8'h00,   6'd0,  5'd0},  1'b1, '{8'h00, 6'd0,  5'd1}},
        // put at bottom-right scrolls
        '{'{tccs_pkg::KIND_GOTO,  8'h00,   6'd63, 5'd31}, 1'b1, '{8'h00, 6'd63, 5'd31}},
        '{'{tccs_pkg::KIND_PUT,   8'h5A,   6'd0,  5'd0},  1'b1, '{8'h00, 6'd0,  5'd31}},
        '{'{tccs_pkg::KIND_READ,  8'h00,   6'd63, 5'd30}, 1'b1, '{8'h5A, 6'd0,  5'd31}},
        '{'{tccs_pkg::KIND_READ,  8'h00,   6'd63, 5'd31}, 1'b1,
          '{tccs_pkg::CHAR_BLANK, 6'd0,  5'd31}},
        '{'{tccs_pkg::KIND_READ,  8'h00,   6'd1,  5'd0},  1'b0, '{8'h00, 6'd0,  5'd0}},
        // line feed and forward on the bottom row also scroll
        '{'{tccs_pkg::KIND_PUT,   tccs_pkg::CHAR_LF, 6'd0, 5'd0}, 1'b1,
          '{8'h00, 6'd0,  5'd31}},
        '{'{tccs_pkg::KIND_GOTO,  8'h00,   6'd63, 5'd31}, 1'b1, '{8'h00, 6'd63, 5'd31}},
        '{'{tccs_pkg::KIND_FWD,   8'h00,   6'd0,  5'd0},  1'b1, '{8'h00, 6'd0,  5'd31}},
        // clear keeps the cursor
        '{'{tccs_pkg::KIND_CLEAR, 8'h00,   6'd0,  5'd0},  1'b1, '{8'h00, 6'd0,  5'd31}},
        '{'{tccs_pkg::KIND_READ,  8'h00,   6'd63, 5'd30}, 1'b1,
          '{tccs_pkg::CHAR_BLANK, 6'd0,  5'd31}},
        // unused kind does nothing
        '{'{KIND_NONE,            8'hFF,   6'd63, 5'd31}, 1'b1, '{8'h00, 6'd0,  5'd31}}
    };

    // ------------------------------------------------------------------------
    // Random command mix, weighted toward puts so rows fill and scroll
    // ------------------------------------------------------------------------
    function automatic t_cmd_word pick_command();
        t_cmd_word c;
        int        sel;
        int        sub;
        sel    = $urandom_range(0, 99);
        sub    = $urandom_range(0, 99);
        c.code = tccs_pkg::CHAR_W'($urandom_range(0, 255));
        c.tcol = tccs_pkg::TCOL_W'($urandom_range(0, COLS - 1));
        c.trow = tccs_pkg::TROW_W'($urandom_range(0, ROWS - 1));
        if (sel < 55) begin
            c.kind = tccs_pkg::KIND_PUT;
            if (sub < 8) begin
                c.code = tccs_pkg::CHAR_LF;
            end else if (sub < 12) begin
                c.code = tccs_pkg::CHAR_CR;
            end
        end else if (sel < 62) begin
            c.kind = tccs_pkg::KIND_SET;
            if (sub < 10) begin
                c.code = (sub < 5) ? tccs_pkg::CHAR_LF : tccs_pkg::CHAR_CR;
            end
        end else if (sel < 67) begin
            c.kind = tccs_pkg::KIND_BACK;
        end else if (sel < 73) begin
            c.kind = tccs_pkg::KIND_FWD;
        end else if (sel < 81) begin
            c.kind = tccs_pkg::KIND_GOTO;
            // lean toward the bottom rows and the last column
            if (sub < 50) begin
                c.trow = tccs_pkg::TROW_W'($urandom_range(ROWS - 3, ROWS - 1));
            end
            if (sub % 4 == 0) begin
                c.tcol = tccs_pkg::TCOL_W'(COLS - 1);
            end
        end else if (sel < 97) begin
            c.kind = tccs_pkg::KIND_READ;
            // half the reads land on the position just written
            if (sub < 50) begin
                c.tcol = tccs_pkg::TCOL_W'((cur_c > 0) ? cur_c - 1 : 0);
                c.trow = tccs_pkg::TROW_W'(cur_r);
            end
        end else if (sel < 99) begin
            c.kind = KIND_NONE;
        end else begin
            c.kind = tccs_pkg::KIND_CLEAR;
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Command sender: one word per call, random gap, waits for acceptance
    // ------------------------------------------------------------------------
    task automatic send_command(input t_cmd_word c, input logic chk, input t_scr_word res);
        int        gap;
        t_scr_word predicted;
        // every fourth block of 64 words goes back to back
        gap = ((tx_count / 64) % 4 == 0) ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= c.kind;
        i_char_code  <= c.code;
        i_target_col <= c.tcol;
        i_target_row <= c.trow;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = console_apply(c);
        pending_words.push_back(chk ? res : predicted);
        kind_seen[c.kind]++;
        tx_count++;
    endtask

    // ------------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int        gap;
        t_scr_word got;
        t_scr_word want;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_count == HOLD_AT) begin
                gap = HOLD_CYCLES;
            end else if ((rx_count / 64) % 4 == 1) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 8);
            end
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got.chr = o_cell_value;
            got.col = o_cursor_col;
            got.row = o_cursor_row;
            if (pending_words.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS) begin
                    $display("result word %0d arrived with no command outstanding",
                             rx_count);
                end
            end else begin
                want = pending_words.pop_front();
                if (got.chr !== want.chr || got.col !== want.col || got.row !== want.row) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display({"word %0d: expected cell %02h col %0d row %0d, ",
                                  "got cell %02h col %0d row %0d"},
                                 rx_count, want.chr, want.col, want.row,
                                 got.chr, got.col, got.row);
                    end
                end
            end
            rx_count++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any cycle that moves a word on either side resets the count
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("no word moved for %0d cycles, %0d results still outstanding",
                 IDLE_LIMIT, pending_words.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        t_cmd_word c;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_kind       = '0;
        i_char_code  = '0;
        i_target_col = '0;
        i_target_row = '0;
        i_out_stall  = 1'b0;
        tx_count     = 0;
        rx_count     = 0;
        err_count    = 0;
        scroll_cnt   = 0;
        foreach (kind_seen[k]) kind_seen[k] = 0;
        blank_screen();
        cur_c = 0;
        cur_r = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_command(dir_rows[i].cmd, dir_rows[i].chk, dir_rows[i].res);
        end

        // random stream
        for (int i = 0; i < N_RANDOM; i++) begin
            c = pick_command();
            send_command(c, 1'b0, '0);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // drain and let any stray word show up
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("ran %0d commands: %0d put, %0d set, %0d back, %0d fwd, %0d goto, %0d read",
                 tx_count, kind_seen[tccs_pkg::KIND_PUT], kind_seen[tccs_pkg::KIND_SET],
                 kind_seen[tccs_pkg::KIND_BACK], kind_seen[tccs_pkg::KIND_FWD],
                 kind_seen[tccs_pkg::KIND_GOTO], kind_seen[tccs_pkg::KIND_READ]);
        $display("%0d clears, %0d unused kind, %0d scrolls; %0d results checked, %0d errors",
                 kind_seen[tccs_pkg::KIND_CLEAR], kind_seen[KIND_NONE], scroll_cnt,
                 rx_count, err_count);
        if (err_count == 0 && pending_words.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
